// ----- hw/rtl/alq_pkg.sv -----
// shared constants, datapath command and status types, reciprocal table
package alq_pkg;

  localparam int MAX_INTERVALS = 1024;

  localparam logic signed [31:0] K_RESET   = 32'sd41943040;
  localparam logic signed [39:0] T_LIMIT   = 40'sd1073741824;
  localparam logic        [33:0] LOG2E_Q30 = 34'd1549082005;
  localparam logic        [33:0] LN2_Q30   = 34'd744261118;
  localparam logic        [63:0] I64MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  // last step counts of the iterative units
  localparam logic [6:0] DIV_LAST  = 7'd71;
  localparam logic [6:0] ROOT_LAST = 7'd63;
  localparam logic [3:0] SER_LAST  = 4'd15;
  localparam logic [6:0] D3_LAST   = 7'd8;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_NFIN,
    OP_MUL_KX,
    OP_MUL_T,
    OP_MUL_Y,
    OP_Z,
    OP_SER_A,
    OP_SER_B,
    OP_SER_C,
    OP_MUL_KM,
    OP_U,
    OP_SQ0,
    OP_SQ1,
    OP_SQ2,
    OP_SQ3,
    OP_ROOT,
    OP_ACC,
    OP_FM0,
    OP_FM1,
    OP_FM2,
    OP_D3,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] j;
  } dp_cmd_t;

  typedef struct packed {
    logic at_b;
  } dp_stat_t;

  // floor(2^32 / j), used with a one-step correction for division by j
  function automatic logic [32:0] recip(input logic [3:0] j);
    logic [32:0] r;
    case (j)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      4'd13:   r = 33'd330382099;
      4'd14:   r = 33'd306783378;
      4'd15:   r = 33'd286331153;
      default: r = 33'd4294967296;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/arc_length_quadrature_core.sv -----
// top level: arc-length quadrature by trapezoid or simpson rule
// each sample point runs a 15-term exp series and a 64-step bit-serial root
// the count uses a 72-step restoring divider, the final scaling 9 byte steps
// one request in flight; the next is taken while a finished result waits
// synchronous active-low reset clears control and sets the rate to 2.5
module arc_length_quadrature_core import alq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_k_gain,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic signed [31:0] in_lower_bound,
  input  logic signed [31:0] in_upper_bound,
  input  logic        [30:0] in_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_integral,
  output logic        [10:0] out_interval_count,
  output logic               out_overflow
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_wr;

  // register writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  alq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  alq_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_wr             (cfg_wr),
    .cfg_k_gain         (cfg_k_gain),
    .in_req_type        (in_req_type),
    .in_lower_bound     (in_lower_bound),
    .in_upper_bound     (in_upper_bound),
    .in_step            (in_step),
    .out_integral       (out_integral),
    .out_interval_count (out_interval_count),
    .out_overflow       (out_overflow)
  );

endmodule

// ----- hw/rtl/alq_dpath.sv -----
// datapath: shared multiplier, series, square root, divider and accumulator
module alq_dpath import alq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_wr,
  input  logic signed [31:0] cfg_k_gain,
  input  logic               in_req_type,
  input  logic signed [31:0] in_lower_bound,
  input  logic signed [31:0] in_upper_bound,
  input  logic        [30:0] in_step,
  output logic signed [63:0] out_integral,
  output logic        [10:0] out_interval_count,
  output logic               out_overflow
);

  logic signed [31:0]  k_r;
  logic                simp_r;
  logic signed [31:0]  b_r;
  logic        [30:0]  h_r;
  logic                npos_r;
  logic        [10:0]  n_r;
  logic                ovf_r;
  logic signed [31:0]  x_r;
  logic        [10:0]  i_r;
  logic                at_b_r;
  logic        [63:0]  acc_r;
  logic signed [67:0]  prod_r;
  logic        [7:0]   ip_r;
  logic        [29:0]  z_r;
  logic        [30:0]  term_r;
  logic        [31:0]  m_r;
  logic        [29:0]  p_r;
  logic        [63:0]  u_r;
  logic        [127:0] rad_r;
  logic        [66:0]  rem_r;
  logic        [63:0]  root_r;
  logic        [62:0]  xh_r;
  logic        [71:0]  dq_r;
  logic        [31:0]  dr_r;
  logic        [31:0]  dv_r;
  logic        [1:0]   rem3_r;
  logic        [63:0]  integral_r;
  logic        [10:0]  count_r;
  logic                ovf_out_r;

  logic signed [33:0]  mul_a;
  logic signed [33:0]  mul_b;
  logic signed [32:0]  diff_in;
  logic                dpos_in;
  logic        [32:0]  div_rs;
  logic                div_ge;
  logic        [31:0]  dr_nxt;
  logic signed [39:0]  t_full;
  logic signed [31:0]  t_c;
  logic        [31:0]  kmag;
  logic        [29:0]  q0;
  logic        [33:0]  qj;
  logic        [33:0]  rr;
  logic        [30:0]  term_nxt;
  logic        [8:0]   sh;
  logic        [8:0]   nsh;
  logic        [63:0]  pw;
  logic                big;
  logic        [63:0]  u_nxt;
  logic                u_ovf;
  logic        [66:0]  rem_sh;
  logic        [66:0]  trial;
  logic                rt_ge;
  logic        [1:0]   wsh;
  logic        [65:0]  wv;
  logic        [66:0]  asum;
  logic                acc_sat;
  logic        [94:0]  xs;
  logic                q_sat;
  logic        [9:0]   d3_c;
  logic        [19:0]  d3_p;
  logic        [7:0]   d3_q;
  logic        [9:0]   d3_rd;
  logic        [7:0]   d3_qd;
  logic        [1:0]   d3_rn;

  // rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_RESET;
    end else if (cfg_wr) begin
      k_r <= cfg_k_gain;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_KX: begin
        mul_a = 34'(k_r);
        mul_b = 34'(x_r);
      end
      OP_MUL_T: begin
        mul_a = 34'(t_c);
        mul_b = $signed(LOG2E_Q30);
      end
      OP_MUL_Y: begin
        mul_a = $signed({4'b0, prod_r[53:30], 6'b0});
        mul_b = $signed(LN2_Q30);
      end
      OP_SER_A: begin
        mul_a = $signed({3'b0, term_r});
        mul_b = $signed({4'b0, z_r});
      end
      OP_SER_B: begin
        mul_a = $signed({4'b0, prod_r[59:30]});
        mul_b = $signed({1'b0, recip(cmd.j)});
      end
      OP_MUL_KM: begin
        mul_a = $signed({2'b0, kmag});
        mul_b = $signed({2'b0, m_r});
      end
      OP_SQ0: begin
        mul_a = $signed({2'b0, u_r[63:32]});
        mul_b = $signed({2'b0, u_r[63:32]});
      end
      OP_SQ1: begin
        mul_a = $signed({2'b0, u_r[63:32]});
        mul_b = $signed({2'b0, u_r[31:0]});
      end
      OP_SQ2: begin
        mul_a = $signed({2'b0, u_r[31:0]});
        mul_b = $signed({2'b0, u_r[31:0]});
      end
      OP_FM0: begin
        mul_a = $signed({2'b0, acc_r[63:32]});
        mul_b = $signed({3'b0, h_r});
      end
      OP_FM1: begin
        mul_a = $signed({2'b0, acc_r[31:0]});
        mul_b = $signed({3'b0, h_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // request range and one restoring divider step
  always_comb begin
    diff_in = 33'(in_upper_bound) - 33'(in_lower_bound);
    dpos_in = !diff_in[32] && (diff_in != 33'd0);
    div_rs  = {dr_r, dq_r[71]};
    div_ge  = div_rs >= {1'b0, dv_r};
    dr_nxt  = div_ge ? 32'(div_rs - {1'b0, dv_r}) : div_rs[31:0];
  end

  // exponent argument clamp and magnitude of the rate
  always_comb begin
    t_full = $signed(prod_r[63:24]);
    if (t_full > T_LIMIT) begin
      t_c = 32'(T_LIMIT);
    end else if (t_full < -T_LIMIT) begin
      t_c = 32'(-T_LIMIT);
    end else begin
      t_c = t_full[31:0];
    end
    kmag = k_r[31] ? 32'(-k_r) : k_r;
  end

  // series term: quotient estimate by reciprocal, then one correction
  always_comb begin
    q0       = prod_r[61:32];
    qj       = 34'(q0) * 34'(cmd.j);
    rr       = {4'b0, p_r} - qj;
    term_nxt = {1'b0, q0} + 31'(rr >= 34'(cmd.j));
  end

  // scale by 2^(ip-22) with saturation
  always_comb begin
    pw    = {1'b0, prod_r[62:0]};
    sh    = {ip_r[7], ip_r} - 9'd22;
    nsh   = -sh;
    big   = 1'b0;
    u_nxt = '0;
    if (!sh[8]) begin
      if (sh[7:0] > 8'd62) begin
        big = pw != 64'd0;
      end else begin
        big = (pw >> (6'd63 - sh[5:0])) != 64'd0;
      end
      u_nxt = big ? I64MAX : (pw << sh[5:0]);
    end else begin
      u_nxt = (nsh[7:0] > 8'd63) ? 64'd0 : (pw >> nsh[5:0]);
    end
    u_ovf = !sh[8] && big;
  end

  // one bit of the square root
  always_comb begin
    rem_sh = {rem_r[64:0], rad_r[127:126]};
    trial  = {1'b0, root_r, 2'b01};
    rt_ge  = rem_sh >= trial;
  end

  // weighted saturating accumulate and final scaling
  always_comb begin
    if (at_b_r || i_r == 11'd0) begin
      wsh = 2'd0;
    end else if (simp_r && i_r[0]) begin
      wsh = 2'd2;
    end else begin
      wsh = 2'd1;
    end
    wv      = {2'b0, root_r} << wsh;
    asum    = {3'b0, acc_r} + {1'b0, wv};
    acc_sat = asum[66:64] != 3'd0;
    xs      = {xh_r, 32'b0} + {32'b0, prod_r[62:0]};
    q_sat   = dq_r[71:63] != 9'd0;
  end

  // one byte of the division by three, a plain rotate for trapezoid
  always_comb begin
    d3_c  = {rem3_r, dq_r[71:64]};
    d3_p  = 20'(d3_c) * 20'd683;
    d3_q  = d3_p[18:11];
    d3_rd = d3_c - {1'b0, d3_q, 1'b0} - {2'b0, d3_q};
    if (simp_r) begin
      d3_qd = d3_q;
      d3_rn = d3_rd[1:0];
    end else begin
      d3_qd = dq_r[71:64];
      d3_rn = 2'd0;
    end
  end

  // registered multiplier
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        simp_r <= in_req_type;
        b_r    <= in_upper_bound;
        h_r    <= in_step;
        npos_r <= dpos_in && (in_step != 31'd0);
        x_r    <= in_lower_bound;
        i_r    <= '0;
        at_b_r <= 1'b0;
        acc_r  <= '0;
        ovf_r  <= 1'b0;
        dq_r   <= dpos_in ? {40'b0, diff_in[31:0]} : 72'd0;
        dr_r   <= '0;
        dv_r   <= {1'b0, in_step};
      end
      OP_DIV: begin
        dr_r <= dr_nxt;
        dq_r <= {dq_r[70:0], div_ge};
      end
      OP_NFIN: begin
        if (!npos_r) begin
          n_r <= '0;
        end else if (dq_r > 72'(MAX_INTERVALS)) begin
          n_r   <= 11'(MAX_INTERVALS);
          ovf_r <= 1'b1;
        end else begin
          n_r <= dq_r[10:0];
        end
      end
      OP_MUL_Y: begin
        ip_r <= prod_r[61:54];
      end
      OP_Z: begin
        z_r    <= prod_r[59:30];
        term_r <= 31'h4000_0000;
        m_r    <= 32'h4000_0000;
      end
      OP_SER_B: begin
        p_r <= prod_r[59:30];
      end
      OP_SER_C: begin
        term_r <= term_nxt;
        m_r    <= m_r + {1'b0, term_nxt};
      end
      OP_U: begin
        u_r   <= u_nxt;
        ovf_r <= ovf_r | u_ovf;
      end
      OP_SQ1: begin
        rad_r <= {prod_r[63:0] + 64'd1, 64'b0};
      end
      OP_SQ2: begin
        rad_r <= rad_r + {31'b0, prod_r[63:0], 33'b0};
      end
      OP_SQ3: begin
        rad_r  <= rad_r + {64'b0, prod_r[63:0]};
        rem_r  <= '0;
        root_r <= '0;
      end
      OP_ROOT: begin
        rem_r  <= rt_ge ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[62:0], rt_ge};
        rad_r  <= {rad_r[125:0], 2'b00};
      end
      OP_ACC: begin
        acc_r <= acc_sat ? {64{1'b1}} : asum[63:0];
        ovf_r <= ovf_r | acc_sat;
        if (!at_b_r) begin
          if ({1'b0, i_r} + 12'd1 < {1'b0, n_r}) begin
            i_r <= i_r + 11'd1;
            x_r <= x_r + $signed({1'b0, h_r});
          end else begin
            at_b_r <= 1'b1;
            x_r    <= b_r;
          end
        end
      end
      OP_FM1: begin
        xh_r <= prod_r[62:0];
      end
      OP_FM2: begin
        // trapezoid halves here, simpson divides by three byte by byte
        dq_r   <= simp_r ? {1'b0, xs[94:24]} : {2'b0, xs[94:25]};
        rem3_r <= '0;
      end
      OP_D3: begin
        dq_r   <= {dq_r[63:0], d3_qd};
        rem3_r <= d3_rn;
      end
      OP_OUT: begin
        integral_r <= q_sat ? I64MAX : dq_r[63:0];
        count_r    <= n_r;
        ovf_out_r  <= ovf_r | q_sat;
      end
      default: begin
      end
    endcase
  end

  assign stat.at_b          = at_b_r;
  assign out_integral       = $signed(integral_r);
  assign out_interval_count = count_r;
  assign out_overflow       = ovf_out_r;

endmodule

// ----- hw/rtl/alq_ctrl.sv -----
// controller: sequences the datapath and runs both handshakes
module alq_ctrl import alq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [22:0] {
    S_IDLE = 23'h000001,
    S_NDIV = 23'h000002,
    S_NFIN = 23'h000004,
    S_KX   = 23'h000008,
    S_T    = 23'h000010,
    S_Y    = 23'h000020,
    S_Z    = 23'h000040,
    S_SA   = 23'h000080,
    S_SB   = 23'h000100,
    S_SC   = 23'h000200,
    S_KM   = 23'h000400,
    S_U    = 23'h000800,
    S_SQ0  = 23'h001000,
    S_SQ1  = 23'h002000,
    S_SQ2  = 23'h004000,
    S_SQ3  = 23'h008000,
    S_RT   = 23'h010000,
    S_ACC  = 23'h020000,
    S_FM0  = 23'h040000,
    S_FM1  = 23'h080000,
    S_FM2  = 23'h100000,
    S_FDIV = 23'h200000,
    S_FOUT = 23'h400000
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  dp_op_t     op;

  // next state, step counter and command
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = OP_NOP;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_LOAD;
          cnt_nxt   = '0;
          state_nxt = S_NDIV;
        end
      end
      S_NDIV: begin
        op = OP_DIV;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_NFIN;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_NFIN: begin
        op        = OP_NFIN;
        state_nxt = S_KX;
      end
      S_KX: begin
        op        = OP_MUL_KX;
        state_nxt = S_T;
      end
      S_T: begin
        op        = OP_MUL_T;
        state_nxt = S_Y;
      end
      S_Y: begin
        op        = OP_MUL_Y;
        state_nxt = S_Z;
      end
      S_Z: begin
        op        = OP_Z;
        cnt_nxt   = 7'd1;
        state_nxt = S_SA;
      end
      S_SA: begin
        op        = OP_SER_A;
        state_nxt = S_SB;
      end
      S_SB: begin
        op        = OP_SER_B;
        state_nxt = S_SC;
      end
      S_SC: begin
        op = OP_SER_C;
        if (cnt_r[3:0] == SER_LAST) begin
          state_nxt = S_KM;
        end else begin
          cnt_nxt   = cnt_r + 7'd1;
          state_nxt = S_SA;
        end
      end
      S_KM: begin
        op        = OP_MUL_KM;
        state_nxt = S_U;
      end
      S_U: begin
        op        = OP_U;
        state_nxt = S_SQ0;
      end
      S_SQ0: begin
        op        = OP_SQ0;
        state_nxt = S_SQ1;
      end
      S_SQ1: begin
        op        = OP_SQ1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        op        = OP_SQ2;
        state_nxt = S_SQ3;
      end
      S_SQ3: begin
        op        = OP_SQ3;
        cnt_nxt   = '0;
        state_nxt = S_RT;
      end
      S_RT: begin
        op = OP_ROOT;
        if (cnt_r == ROOT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_ACC: begin
        op        = OP_ACC;
        state_nxt = stat.at_b ? S_FM0 : S_KX;
      end
      S_FM0: begin
        op        = OP_FM0;
        state_nxt = S_FM1;
      end
      S_FM1: begin
        op        = OP_FM1;
        state_nxt = S_FM2;
      end
      S_FM2: begin
        op        = OP_FM2;
        cnt_nxt   = '0;
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        op = OP_D3;
        if (cnt_r == D3_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_FOUT;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_FOUT: begin
        // result register must be free or emptying this cycle
        if (!out_valid_r || out_ready) begin
          op            = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.op    = op;
  assign cmd.j     = cnt_r[3:0];
  assign out_valid = out_valid_r;

  // a result appears only from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FOUT)
    else $error("result raised outside output state");

  // a waiting result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOUT && out_valid_r && !out_ready) |=> (state_r == S_FOUT && out_valid_r))
    else $error("pending result overwritten");

  // step counter stays within the longest loop
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DIV_LAST)
    else $error("step counter out of range");

  // an accepted request always starts the count division
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_NDIV && cnt_r == 7'd0))
    else $error("request did not start division");

endmodule
